// File: design/nearest_texel_sampler_clamp_assert.svh
// assertion macros for the nearest texel sampler
// expects clk and arst_n in the scope of each use
`ifndef NEAREST_TEXEL_SAMPLER_CLAMP_ASSERT_SVH
`define NEAREST_TEXEL_SAMPLER_CLAMP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define NTSC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define NTSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/ntsc_pkg.sv
// shared types and constants for the nearest texel sampler
// no dependencies
package ntsc_pkg;

	// default sizing
	localparam int unsigned TEXEL_DEPTH_DEF     = 65536;
	localparam int unsigned MAX_SIDE_DEF        = 256;
	localparam int unsigned COORD_FRAC_BITS_DEF = 15;

	// payload widths
	localparam int ADDR_W  = 16;
	localparam int BYTE_W  = 8;
	localparam int COORD_W = 18;
	localparam int DIM_W   = 9;

	// configuration port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_TEX_WIDTH  = 2'd0;
	localparam logic [1:0] REG_TEX_HEIGHT = 2'd1;
	localparam logic [1:0] REG_HAS_ALPHA  = 2'd2;

	// item opcodes
	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	// one stored texel
	typedef struct packed {
		logic [BYTE_W-1:0] alpha;
		logic [BYTE_W-1:0] blue;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] red;
	} texel_t;

endpackage

// File: design/ntsc_ram.sv
// generic single-write, single-read RAM with registered read data
// no dependencies
module ntsc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/nearest_texel_sampler_clamp.sv
// nearest texel sampler with edge clamping, top level
// depends on ntsc_pkg, ntsc_ram and nearest_texel_sampler_clamp_assert.svh
//
// Usage:
// - req channel (req_valid/req_ready) carries one item per transfer: opcode
//   write stores {alpha,blue,green,red} at texel_addr, opcode sample looks up
//   the texel nearest to (coord_u, coord_v) after clamping both to [0,1].
// - rsp channel (rsp_valid/rsp_ready) carries one result per sample item;
//   write items give no result.
// - APB port holds tex_width (0x0), tex_height (0x4) and has_alpha (0x8);
//   write it only while the block is idle.
// A sample loads stage one when accepted, then passes stages two to five and the
//   RAM output register before it shows on rsp_valid; a stall can hold it on the way.
// Throughput: one item per clock unless the receiver stalls; the texel RAM takes one
//   write or one read per cycle, in item order, so a sample always sees earlier writes.
// Reset clears all valid bits and the loaded flag, and sets width 1, height 1
//   and no alpha. Texel contents stay undefined, no clearing pass; until the
//   first write, samples return opaque black.
// When the receiver stalls, the result holds and earlier stages fill their
//   bubbles; req_ready drops only when every stage is full.
`include "nearest_texel_sampler_clamp_assert.svh"

module nearest_texel_sampler_clamp #(
	parameter int unsigned TEXEL_DEPTH     = ntsc_pkg::TEXEL_DEPTH_DEF,
	parameter int unsigned MAX_SIDE        = ntsc_pkg::MAX_SIDE_DEF,
	parameter int unsigned COORD_FRAC_BITS = ntsc_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [ntsc_pkg::PADDR_W-1:0]       paddr,
	input  logic [ntsc_pkg::PDATA_W-1:0]       pwdata,
	output logic [ntsc_pkg::PDATA_W-1:0]       prdata,
	output logic                               pready,
	// request channel
	input  logic                               req_valid,
	output logic                               req_ready,
	input  logic                               opcode,
	input  logic [ntsc_pkg::ADDR_W-1:0]        texel_addr,
	input  logic [ntsc_pkg::BYTE_W-1:0]        in_red,
	input  logic [ntsc_pkg::BYTE_W-1:0]        in_green,
	input  logic [ntsc_pkg::BYTE_W-1:0]        in_blue,
	input  logic [ntsc_pkg::BYTE_W-1:0]        in_alpha,
	input  logic signed [ntsc_pkg::COORD_W-1:0] coord_u,
	input  logic signed [ntsc_pkg::COORD_W-1:0] coord_v,
	// response channel
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output logic [ntsc_pkg::BYTE_W-1:0]        out_red,
	output logic [ntsc_pkg::BYTE_W-1:0]        out_green,
	output logic [ntsc_pkg::BYTE_W-1:0]        out_blue,
	output logic [ntsc_pkg::BYTE_W-1:0]        out_alpha
);
	import ntsc_pkg::*;

	// derived widths
	localparam int unsigned AW  = (TEXEL_DEPTH > 1) ? $clog2(TEXEL_DEPTH) : 1;
	localparam int unsigned DW  = $clog2(TEXEL_DEPTH + 1);
	localparam int unsigned SW1 = $clog2(MAX_SIDE + 1);
	localparam int unsigned SW  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int unsigned IW  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1;
	localparam int unsigned CW  = COORD_FRAC_BITS + 1;
	localparam int unsigned PW  = CW + SW;
	localparam int          ONE_V = 1 << COORD_FRAC_BITS;
	// reciprocal of the depth, scaled by 2^IW, for the index wrap
	localparam longint unsigned RECIP_L = (64'd1 << IW) / TEXEL_DEPTH;
	localparam logic [IW:0]     RECIP   = (IW + 1)'(RECIP_L);

	// configuration registers
	logic [DIM_W-1:0] tex_width_q;
	logic [DIM_W-1:0] tex_height_q;
	logic             has_alpha_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q  <= DIM_W'(1);
			tex_height_q <= DIM_W'(1);
			has_alpha_q  <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_TEX_WIDTH:  tex_width_q  <= pwdata[DIM_W-1:0];
				REG_TEX_HEIGHT: tex_height_q <= pwdata[DIM_W-1:0];
				REG_HAS_ALPHA:  has_alpha_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[3:2])
			REG_TEX_WIDTH:  prdata = PDATA_W'(tex_width_q);
			REG_TEX_HEIGHT: prdata = PDATA_W'(tex_height_q);
			REG_HAS_ALPHA:  prdata = PDATA_W'(has_alpha_q);
			default:        prdata = '0;
		endcase
	end

	// effective texture sides, zero acts as one, capped at MAX_SIDE
	logic [SW1-1:0] w_eff, h_eff;
	logic [SW-1:0]  w_m1, h_m1;

	always_comb begin
		if (tex_width_q == '0) begin
			w_eff = SW1'(1);
		end else if (32'(tex_width_q) > 32'(MAX_SIDE)) begin
			w_eff = SW1'(MAX_SIDE);
		end else begin
			w_eff = SW1'(tex_width_q);
		end
		if (tex_height_q == '0) begin
			h_eff = SW1'(1);
		end else if (32'(tex_height_q) > 32'(MAX_SIDE)) begin
			h_eff = SW1'(MAX_SIDE);
		end else begin
			h_eff = SW1'(tex_height_q);
		end
	end

	assign w_m1 = SW'(w_eff - SW1'(1));
	assign h_m1 = SW'(h_eff - SW1'(1));

	// stage enables, a stage loads when empty or when it drains
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6 = !v_s6 || rsp_ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign req_ready = en1;

	// stage payloads
	op_t            op_s1, op_s2, op_s3, op_s4, op_s5;
	logic           wr_ok_s1, wr_ok_s2, wr_ok_s3, wr_ok_s4, wr_ok_s5;
	logic [AW-1:0]  waddr_s1, waddr_s2, waddr_s3, waddr_s4;
	texel_t         wdata_s1, wdata_s2, wdata_s3, wdata_s4, wdata_s5;
	logic [CW-1:0]  cu_s1, cv_s1;
	logic [SW-1:0]  x_s2, y_s2;
	logic [IW-1:0]  idx_s3, idx_s4;
	logic [IW-1:0]  q_s4;
	logic [AW-1:0]  addr_s5;
	logic           loaded_s6;
	logic           store_loaded_q;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= req_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5 && (op_s5 == OP_SAMPLE);
		end
	end

	// stage 1: clamp coordinates to [0,1], check write address
	logic signed [31:0] cu_w, cv_w;
	logic [CW-1:0]      cu_c, cv_c;

	assign cu_w = 32'(coord_u);
	assign cv_w = 32'(coord_v);
	assign cu_c = (cu_w < 0) ? '0 : (cu_w > ONE_V) ? CW'(ONE_V) : CW'(cu_w);
	assign cv_c = (cv_w < 0) ? '0 : (cv_w > ONE_V) ? CW'(ONE_V) : CW'(cv_w);

	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1    <= op_t'(opcode);
			wr_ok_s1 <= 32'(texel_addr) < 32'(TEXEL_DEPTH);
			waddr_s1 <= AW'(texel_addr);
			wdata_s1 <= '{alpha: in_alpha, blue: in_blue, green: in_green, red: in_red};
			cu_s1    <= cu_c;
			cv_s1    <= cv_c;
		end
	end

	// stage 2: scale by side minus one, truncate
	logic [PW-1:0] px, py;

	assign px = PW'(cu_s1) * PW'(w_m1);
	assign py = PW'(cv_s1) * PW'(h_m1);

	always_ff @(posedge clk) begin
		if (en2) begin
			op_s2    <= op_s1;
			wr_ok_s2 <= wr_ok_s1;
			waddr_s2 <= waddr_s1;
			wdata_s2 <= wdata_s1;
			x_s2     <= px[COORD_FRAC_BITS +: SW];
			y_s2     <= py[COORD_FRAC_BITS +: SW];
		end
	end

	// stage 3: linear index y*width+x
	always_ff @(posedge clk) begin
		if (en3) begin
			op_s3    <= op_s2;
			wr_ok_s3 <= wr_ok_s2;
			waddr_s3 <= waddr_s2;
			wdata_s3 <= wdata_s2;
			idx_s3   <= IW'(y_s2) * IW'(w_eff) + IW'(x_s2);
		end
	end

	// stage 4: quotient estimate by the depth, low by at most one
	logic [2*IW:0] qprod;

	assign qprod = (2 * IW + 1)'(idx_s3) * (2 * IW + 1)'(RECIP);

	always_ff @(posedge clk) begin
		if (en4) begin
			op_s4    <= op_s3;
			wr_ok_s4 <= wr_ok_s3;
			waddr_s4 <= waddr_s3;
			wdata_s4 <= wdata_s3;
			idx_s4   <= idx_s3;
			q_s4     <= qprod[IW +: IW];
		end
	end

	// stage 5: remainder with one correction, pick the RAM address
	logic [IW+DW-1:0] qd;
	logic [IW-1:0]    rem0, rem1;

	assign qd   = (IW + DW)'(q_s4) * (IW + DW)'(TEXEL_DEPTH);
	assign rem0 = idx_s4 - qd[IW-1:0];
	assign rem1 = (32'(rem0) >= 32'(TEXEL_DEPTH)) ? rem0 - IW'(TEXEL_DEPTH) : rem0;

	always_ff @(posedge clk) begin
		if (en5) begin
			op_s5    <= op_s4;
			wr_ok_s5 <= wr_ok_s4;
			wdata_s5 <= wdata_s4;
			addr_s5  <= (op_s4 == OP_WRITE) ? waddr_s4 : AW'(rem1);
		end
	end

	// texel RAM access, one write or one read as stage 5 drains
	logic   ram_we, ram_re;
	texel_t ram_rdata;

	assign ram_we = en6 && v_s5 && (op_s5 == OP_WRITE) && wr_ok_s5;
	assign ram_re = en6 && v_s5 && (op_s5 == OP_SAMPLE);

	ntsc_ram #(
		.WIDTH ($bits(texel_t)),
		.DEPTH (TEXEL_DEPTH)
	) u_texel_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s5),
		.wdata (wdata_s5),
		.re    (ram_re),
		.raddr (addr_s5),
		.rdata (ram_rdata)
	);

	// loaded flag, set by the first stored write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_loaded_q <= 1'b0;
		end else if (ram_we) begin
			store_loaded_q <= 1'b1;
		end
	end

	// stage 6 sideband, travels with the RAM output register
	always_ff @(posedge clk) begin
		if (ram_re) begin
			loaded_s6 <= store_loaded_q;
		end
	end

	// response formatting
	assign rsp_valid = v_s6;
	assign out_red   = loaded_s6 ? ram_rdata.red   : '0;
	assign out_green = loaded_s6 ? ram_rdata.green : '0;
	assign out_blue  = loaded_s6 ? ram_rdata.blue  : '0;
	assign out_alpha = (loaded_s6 && has_alpha_q) ? ram_rdata.alpha : '1;

	// checks
	`NTSC_ASSERT_NOW(a_ram_one_op, ram_we, !ram_re, "texel RAM read and write in one cycle")
	`NTSC_ASSERT_NEXT(a_loaded_set, ram_we, store_loaded_q, "stored write did not set loaded flag")
	`NTSC_ASSERT_NEXT(a_loaded_sticky, store_loaded_q, store_loaded_q, "loaded flag cleared")
	`NTSC_ASSERT_NEXT(a_write_no_rsp, en6 && v_s5 && (op_s5 == OP_WRITE), !v_s6,
		"write item produced a response")
	`NTSC_ASSERT_NOW(a_addr_range, v_s5 && (op_s5 == OP_SAMPLE),
		32'(addr_s5) < 32'(TEXEL_DEPTH), "sample index not wrapped into the store")

endmodule

// File: dv/nearest_texel_sampler_clamp_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for nearest_texel_sampler_clamp: texel writes and samples over
// several texture shapes, with a texture shadow that predicts every sampled texel
// depends on ntsc_pkg and the nearest_texel_sampler_clamp rtl

// one request transfer
typedef struct {
	ntsc_pkg::op_t                           op;
	logic [ntsc_pkg::ADDR_W-1:0]             addr;
	ntsc_pkg::texel_t                        data;
	logic signed [ntsc_pkg::COORD_W-1:0]     u;
	logic signed [ntsc_pkg::COORD_W-1:0]     v;
} sampler_item_t;

// shadow copy of the texture and registers, plus the texels still owed by the block
class texture_shadow;
	ntsc_pkg::texel_t texels [bit [ntsc_pkg::ADDR_W-1:0]];
	ntsc_pkg::texel_t pending_texels [$];
	bit loaded;
	bit [ntsc_pkg::DIM_W-1:0] width_reg;
	bit [ntsc_pkg::DIM_W-1:0] height_reg;
	bit alpha_en;
	int unsigned writes_seen;
	int unsigned samples_seen;
	int unsigned checked;
	int unsigned mismatches;

	function new();
		loaded = 1'b0;
		width_reg = 1;
		height_reg = 1;
		alpha_en = 1'b0;
		writes_seen = 0;
		samples_seen = 0;
		checked = 0;
		mismatches = 0;
	endfunction

	function void set_reg(logic [1:0] idx, logic [ntsc_pkg::PDATA_W-1:0] value);
		case (idx)
			ntsc_pkg::REG_TEX_WIDTH: begin
				width_reg = value[ntsc_pkg::DIM_W-1:0];
			end
			ntsc_pkg::REG_TEX_HEIGHT: begin
				height_reg = value[ntsc_pkg::DIM_W-1:0];
			end
			ntsc_pkg::REG_HAS_ALPHA: begin
				alpha_en = value[0];
			end
			default: begin
			end
		endcase
	endfunction

	// zero acts as one, oversize saturates at the largest side
	function int unsigned eff_side(bit [ntsc_pkg::DIM_W-1:0] s);
		if (s == 0) return 1;
		if (s > ntsc_pkg::MAX_SIDE_DEF) return ntsc_pkg::MAX_SIDE_DEF;
		return s;
	endfunction

	// clamp to [0,1], scale by side-1, truncate
	function int unsigned texel_coord(logic signed [ntsc_pkg::COORD_W-1:0] c,
			int unsigned s);
		int one;
		longint unsigned cl;
		one = 1 << ntsc_pkg::COORD_FRAC_BITS_DEF;
		if (c < 0) cl = 0;
		else if (c > one) cl = one;
		else cl = c;
		return (cl * (s - 1)) >> ntsc_pkg::COORD_FRAC_BITS_DEF;
	endfunction

	function bit [ntsc_pkg::ADDR_W-1:0] lookup_index(logic signed [ntsc_pkg::COORD_W-1:0] u,
			logic signed [ntsc_pkg::COORD_W-1:0] v);
		int unsigned w;
		int unsigned x;
		int unsigned y;
		w = eff_side(width_reg);
		x = texel_coord(u, w);
		y = texel_coord(v, eff_side(height_reg));
		return (y * w + x) % ntsc_pkg::TEXEL_DEPTH_DEF;
	endfunction

	// accepted request: update the store or queue the texel the block owes
	function void note_item(sampler_item_t it);
		ntsc_pkg::texel_t t;
		bit [ntsc_pkg::ADDR_W-1:0] idx;
		if (it.op == ntsc_pkg::OP_WRITE) begin
			texels[it.addr] = it.data;
			loaded = 1'b1;
			writes_seen++;
		end else begin
			samples_seen++;
			t = '0;
			if (!loaded) begin
				t.alpha = 8'hFF;
			end else begin
				idx = lookup_index(it.u, it.v);
				if (texels.exists(idx)) t = texels[idx];
				if (!alpha_en) t.alpha = 8'hFF;
			end
			pending_texels.push_back(t);
		end
	endfunction

	// accepted result: compare with the oldest owed texel
	function void check_texel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
		ntsc_pkg::texel_t want;
		if (pending_texels.size() == 0) begin
			$error("result with no sample outstanding: r=%0d g=%0d b=%0d a=%0d", r, g, b, a);
			mismatches++;
			return;
		end
		want = pending_texels.pop_front();
		checked++;
		if (r !== want.red) begin
			$error("out_red expected %0d got %0d", want.red, r);
			mismatches++;
		end
		if (g !== want.green) begin
			$error("out_green expected %0d got %0d", want.green, g);
			mismatches++;
		end
		if (b !== want.blue) begin
			$error("out_blue expected %0d got %0d", want.blue, b);
			mismatches++;
		end
		if (a !== want.alpha) begin
			$error("out_alpha expected %0d got %0d", want.alpha, a);
			mismatches++;
		end
	endfunction
endclass

module nearest_texel_sampler_clamp_tb;
	import ntsc_pkg::*;

	localparam int     PERIOD      = 20;
	localparam int     SETTLE      = 16;
	localparam int     HOLD_CYCLES = 300;
	localparam int     PHASE_ITEMS = 120;
	localparam int     NUM_PHASES  = 8;
	localparam longint LIMIT_NS    = 10_000_000;

	logic                      clk        = 1'b0;
	logic                      arst_n     = 1'b0;
	logic                      psel       = 1'b0;
	logic                      penable    = 1'b0;
	logic                      pwrite     = 1'b0;
	logic [PADDR_W-1:0]        paddr      = '0;
	logic [PDATA_W-1:0]        pwdata     = '0;
	logic [PDATA_W-1:0]        prdata;
	logic                      pready;
	logic                      req_valid  = 1'b0;
	logic                      req_ready;
	logic                      opcode     = 1'b0;
	logic [ADDR_W-1:0]         texel_addr = '0;
	logic [BYTE_W-1:0]         in_red     = '0;
	logic [BYTE_W-1:0]         in_green   = '0;
	logic [BYTE_W-1:0]         in_blue    = '0;
	logic [BYTE_W-1:0]         in_alpha   = '0;
	logic signed [COORD_W-1:0] coord_u    = '0;
	logic signed [COORD_W-1:0] coord_v    = '0;
	logic                      rsp_valid;
	logic                      rsp_ready  = 1'b0;
	logic [BYTE_W-1:0]         out_red;
	logic [BYTE_W-1:0]         out_green;
	logic [BYTE_W-1:0]         out_blue;
	logic [BYTE_W-1:0]         out_alpha;

	logic        hold_off  = 1'b0;
	int unsigned stall_pct = 0;
	int unsigned idle_pct  = 0;

	texture_shadow shadow;

	nearest_texel_sampler_clamp uut (.*);

	// clock
	initial begin
		forever #(PERIOD / 2) clk = ~clk;
	end

	// run limit
	initial begin
		#(LIMIT_NS);
		$display("nearest_texel_sampler_clamp test failed");
		$finish;
	end

	// receiver: random stalls, or a long hold-off when asked
	always @(posedge clk) begin
		if (hold_off) rsp_ready <= 1'b0;
		else rsp_ready <= ($urandom_range(99) >= stall_pct);
	end

	// check every result transfer
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			shadow.check_texel(out_red, out_green, out_blue, out_alpha);
	end

	// mostly inside [0,1], some exact edges, some anywhere in the field
	function automatic logic signed [COORD_W-1:0] rand_coord();
		int unsigned pick;
		pick = $urandom_range(9);
		if (pick < 6) return $urandom_range(32768);
		if (pick == 6) begin
			case ($urandom_range(5))
				0: return 0;
				1: return 1;
				2: return 32767;
				3: return 32768;
				4: return -1;
				default: return 32769;
			endcase
		end
		return COORD_W'($urandom);
	endfunction

	// one request transfer, with random idle cycles ahead of it
	task automatic push_item(sampler_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid  <= 1'b1;
		opcode     <= it.op;
		texel_addr <= it.addr;
		in_red     <= it.data.red;
		in_green   <= it.data.green;
		in_blue    <= it.data.blue;
		in_alpha   <= it.data.alpha;
		coord_u    <= it.u;
		coord_v    <= it.v;
		do begin
			@(posedge clk);
		end while (!req_ready);
		shadow.note_item(it);
	endtask

	task automatic send_write(logic [ADDR_W-1:0] addr, texel_t data);
		sampler_item_t it;
		it.op   = OP_WRITE;
		it.addr = addr;
		it.data = data;
		it.u    = COORD_W'($urandom);
		it.v    = COORD_W'($urandom);
		push_item(it);
	endtask

	// sample; once the store is loaded, the target texel gets written first if it never was, or if refresh asks
	task automatic send_sample(logic signed [COORD_W-1:0] u, logic signed [COORD_W-1:0] v,
			bit refresh);
		sampler_item_t it;
		bit [ADDR_W-1:0] idx;
		if (shadow.loaded) begin
			idx = shadow.lookup_index(u, v);
			if (refresh || !shadow.texels.exists(idx)) send_write(idx, $urandom);
		end
		it.op   = OP_SAMPLE;
		it.addr = $urandom;
		it.data = $urandom;
		it.u    = u;
		it.v    = v;
		push_item(it);
	endtask

	// drop valid, wait for every owed result, then let writes in flight retire
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (shadow.pending_texels.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apb_write(logic [1:0] idx, logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		shadow.set_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic configure(int unsigned w, int unsigned h, bit alpha);
		wait_idle();
		apb_write(REG_TEX_WIDTH, w);
		apb_write(REG_TEX_HEIGHT, h);
		apb_write(REG_HAS_ALPHA, alpha);
	endtask

	// stimulus
	initial begin
		int unsigned cfg_w [NUM_PHASES];
		int unsigned cfg_h [NUM_PHASES];
		bit          cfg_a [NUM_PHASES];
		int unsigned pick;
		int unsigned w;
		int unsigned h;
		int unsigned x;
		int unsigned y;

		shadow = new();
		// full size, 1x1, zero sides, oversize sides, single row, single column, random
		cfg_w = '{256, 1, 0, 511, 256, 1, 0, 0};
		cfg_h = '{256, 1, 0, 300, 1, 256, 0, 0};
		cfg_a = '{1, 0, 1, 0, 1, 0, 0, 1};
		cfg_w[6] = $urandom_range(1, 256);
		cfg_h[6] = $urandom_range(1, 256);
		cfg_a[6] = $urandom_range(1);
		cfg_w[7] = $urandom_range(2, 16);
		cfg_h[7] = $urandom_range(2, 16);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store reads back opaque black
		configure(256, 256, 1'b1);
		send_sample(-131072, -131072, 1'b0);
		send_sample(131071, 131071, 1'b0);
		send_sample(0, 32768, 1'b0);

		// corners and byte extremes, clamped coordinates, write then read back-to-back
		send_write(0, 32'h0000_0000);
		send_write(16'hFFFF, 32'hFFFF_FFFF);
		send_write(255, 32'h8040_2010);
		send_write(65280, 32'h0102_0304);
		send_sample(-131072, -131072, 1'b0);
		send_sample(131071, 131071, 1'b0);
		send_sample(32768, -1, 1'b0);
		send_sample(-1, 32768, 1'b0);
		send_sample(32767, 32767, 1'b0);
		send_sample(32768, 32768, 1'b1);
		send_sample(1, 32769, 1'b0);

		// random phases over shapes and idle patterns
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			configure(cfg_w[ph], cfg_h[ph], cfg_a[ph]);
			case (ph % 4)
				0: begin
					idle_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					idle_pct = 82;
					stall_pct <= 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct <= 82;
				end
				default: begin
					idle_pct = 10;
					stall_pct <= 10;
				end
			endcase
			// long receiver hold-off so the pipeline fills and back-pressures
			if (ph == 0) begin
				fork
					begin
						hold_off <= 1'b1;
						repeat (HOLD_CYCLES) @(posedge clk);
						hold_off <= 1'b0;
					end
				join_none
			end
			w = shadow.eff_side(shadow.width_reg);
			h = shadow.eff_side(shadow.height_reg);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(99);
				if (pick < 50) begin
					send_sample(rand_coord(), rand_coord(), $urandom_range(3) == 0);
				end else if (pick < 80) begin
					x = $urandom_range(w - 1);
					y = $urandom_range(h - 1);
					send_write(ADDR_W'(y * w + x), $urandom);
				end else begin
					send_write($urandom, $urandom);
				end
			end
		end

		wait_idle();
		$display("%0d transfers in: %0d texel writes, %0d samples; %0d results checked",
			shadow.writes_seen + shadow.samples_seen, shadow.writes_seen,
			shadow.samples_seen, shadow.checked);
		$display("shapes 1x1 to 256x256 incl. zero and oversize sides, alpha on/off, stalls");
		if (shadow.mismatches == 0) begin
			$display("nearest_texel_sampler_clamp test passed");
		end else begin
			$display("nearest_texel_sampler_clamp test failed");
		end
		$finish;
	end

endmodule
